### src/lrs_pkg.sv
`default_nettype none
package lrs_pkg;

  // Counter width covers positions up to the largest supported feature count plus one
  localparam int CntW = 11;

  localparam int SigEntries = 256;
  localparam int SigIdxW = 8;
  localparam longint unsigned Q30One = 64'd1 << 30;

  typedef struct packed {
    logic            train;
    logic            label;
    logic            len_err;
    logic [CntW-1:0] got;
    logic [CntW-1:0] n;
  } meta_t;

  typedef struct packed {
    logic        cls;
    logic [15:0] prob;
    meta_t       meta;
  } q_entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RD,
    B_MUL,
    B_GRAD,
    B_LO,
    B_HI,
    B_WR,
    B_BIAS
  } back_state_e;

  typedef enum logic [1:0] {
    REG_FEATURE_COUNT = 2'd0,
    REG_LEARNING_RATE = 2'd1,
    REG_REG_LAMBDA    = 2'd2
  } cfg_reg_e;

endpackage
`default_nettype wire

### src/logistic_regression_sgd_unit.sv
// Logistic regression scorer with online SGD training.
// Input stream: one feature per transfer (tdata = signed Q4.12 value),
// tlast on the final feature, tuser = {label, command}; command 1 trains.
// Output stream: one transfer per sample: class, Q0.16 probability and
// a length error flag. Configuration writes (feature count, learning rate,
// L2 weight) go through cfg_we_i/cfg_idx_i/cfg_data_i; the user must make
// them only while idle, as the block does not enforce it. Features are
// taken one per cycle while input ready is high; each goes through a
// three-stage multiply-accumulate against the weight memory (capture with
// weight read, product, saturating accumulate), then a sigmoid lookup
// hands the result to the queue. After a training sample the weight
// memory is rewritten by a sequencer that reads, multiplies, forms the
// gradient, scales it in low and high halves and writes back each weight
// in turn, then updates the bias. Input ready stays low after each tlast
// until a predict result is queued or a training update ends. A two-entry
// queue and an output register let results wait while the receiver stalls
// without blocking the next predict sample. Reset zeroes weights, bias and
// counters and loads the register defaults; no clearing pass is needed.
`default_nettype none
module logistic_regression_sgd_unit #(
  parameter int MAX_FEATURES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] feature_value
  input  wire logic        s_axis_tlast,   // feature_last
  input  wire logic [1:0]  s_axis_tuser,   // [0] command, [1] label
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [0] predicted_class, [16:1] probability,
                                           // [17] length_error, [23:18] zero
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  logic [6:0]  feature_count_q;
  logic [15:0] learning_rate_q;
  logic [15:0] reg_lambda_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feature_count_q <= 7'd8;
      learning_rate_q <= 16'd655;
      reg_lambda_q    <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lrs_pkg::REG_FEATURE_COUNT: feature_count_q <= cfg_data_i[6:0];
        lrs_pkg::REG_LEARNING_RATE: learning_rate_q <= cfg_data_i;
        lrs_pkg::REG_REG_LAMBDA:    reg_lambda_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [AW-1:0]      wt_addr, sb_raddr;
  logic signed [31:0] wt_word, bias;
  logic signed [15:0] sb_rdata;
  logic               q_full, q_avail, q_pop, push, upd_done;
  lrs_pkg::q_entry_t  push_entry, q_head;
  logic               out_cls, out_len_err;
  logic [15:0]        out_prob;

  lrs_front #(.MAX_FEATURES(MAX_FEATURES)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .feature_count_i(feature_count_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_value_i     (s_axis_tdata),
    .in_last_i      (s_axis_tlast),
    .in_cmd_i       (s_axis_tuser[0]),
    .in_label_i     (s_axis_tuser[1]),
    .wt_addr_o      (wt_addr),
    .wt_word_i      (wt_word),
    .bias_i         (bias),
    .sb_raddr_i     (sb_raddr),
    .sb_rdata_o     (sb_rdata),
    .q_full_i       (q_full),
    .upd_done_i     (upd_done),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  lrs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .avail_o     (q_avail),
    .head_o      (q_head)
  );

  lrs_back #(.MAX_FEATURES(MAX_FEATURES)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .learning_rate_i(learning_rate_q),
    .reg_lambda_i   (reg_lambda_q),
    .q_avail_i      (q_avail),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .front_addr_i   (wt_addr),
    .wt_word_o      (wt_word),
    .bias_o         (bias),
    .sb_raddr_o     (sb_raddr),
    .sb_rdata_i     (sb_rdata),
    .upd_done_o     (upd_done),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_cls_o      (out_cls),
    .out_prob_o     (out_prob),
    .out_len_err_o  (out_len_err)
  );

  assign m_axis_tdata = {6'd0, out_len_err, out_prob, out_cls};

endmodule
`default_nettype wire

### src/lrs_queue.sv
`default_nettype none
module lrs_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lrs_pkg::q_entry_t push_entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   avail_o,
  output lrs_pkg::q_entry_t      head_o
);

  lrs_pkg::q_entry_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

### src/lrs_front.sv
`default_nettype none
module lrs_front #(
  parameter int MAX_FEATURES = 64,
  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [6:0]          feature_count_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic signed [15:0]  in_value_i,
  input  wire logic                in_last_i,
  input  wire logic                in_cmd_i,
  input  wire logic                in_label_i,
  output logic [AW-1:0]            wt_addr_o,
  input  wire logic signed [31:0]  wt_word_i,
  input  wire logic signed [31:0]  bias_i,
  input  wire logic [AW-1:0]       sb_raddr_i,
  output logic signed [15:0]       sb_rdata_o,
  input  wire logic                q_full_i,
  input  wire logic                upd_done_i,
  output logic                     push_o,
  output lrs_pkg::q_entry_t        push_entry_o
);

  localparam logic [lrs_pkg::CntW-1:0] MaxCnt = lrs_pkg::CntW'(MAX_FEATURES);

  logic signed [15:0] sbuf [MAX_FEATURES];

  logic [lrs_pkg::CntW-1:0] fidx_q, fidx_d, fidx_inc, n_eff, got;
  logic hold_q, hold_d;
  logic accept, in_range;

  logic               s1_v_q, s1_in_q, s1_first_q, s1_last_q;
  logic signed [15:0] s1_x_q;
  lrs_pkg::meta_t     s1_meta_q;

  logic               s2_v_q, s2_first_q, s2_last_q;
  logic signed [47:0] s2_prod_q;
  lrs_pkg::meta_t     s2_meta_q;

  logic               s3_v_q;
  logic signed [47:0] acc_q;
  lrs_pkg::meta_t     s3_meta_q;

  logic signed [47:0] acc_base;
  logic signed [48:0] acc_sum;
  logic signed [47:0] acc_d;
  localparam int SigIdxWLocal = lrs_pkg::SigIdxW;
  logic [SigIdxWLocal-1:0] sig_idx;
  logic signed [48:0] z_off;
  logic [15:0] prob;
  logic [15:0] sig_rom [lrs_pkg::SigEntries];

  // Sigmoid at cell midpoints over [-8,8), Q0.16, fixed at elaboration
  for (genvar gi = 0; gi < lrs_pkg::SigEntries; gi++) begin : g_sig
    localparam longint unsigned One = lrs_pkg::Q30One;
    localparam longint D = 2 * gi + 1 - lrs_pkg::SigEntries;
    localparam longint unsigned Mag = $unsigned((D < 0) ? -D : D);
    localparam longint unsigned V = (Mag << 29) / lrs_pkg::SigEntries;
    localparam longint unsigned E12 = One - ((V * One) >> 30) / 12;
    localparam longint unsigned E11 = One - ((V * E12) >> 30) / 11;
    localparam longint unsigned E10 = One - ((V * E11) >> 30) / 10;
    localparam longint unsigned E9 = One - ((V * E10) >> 30) / 9;
    localparam longint unsigned E8 = One - ((V * E9) >> 30) / 8;
    localparam longint unsigned E7 = One - ((V * E8) >> 30) / 7;
    localparam longint unsigned E6 = One - ((V * E7) >> 30) / 6;
    localparam longint unsigned E5 = One - ((V * E6) >> 30) / 5;
    localparam longint unsigned E4 = One - ((V * E5) >> 30) / 4;
    localparam longint unsigned E3 = One - ((V * E4) >> 30) / 3;
    localparam longint unsigned E2 = One - ((V * E3) >> 30) / 2;
    localparam longint unsigned E1 = One - ((V * E2) >> 30);
    localparam longint unsigned S1 = (E1 * E1) >> 30;
    localparam longint unsigned S2 = (S1 * S1) >> 30;
    localparam longint unsigned S3 = (S2 * S2) >> 30;
    localparam longint unsigned S4 = (S3 * S3) >> 30;
    localparam longint unsigned Den = One + S4;
    localparam longint unsigned Num = (D >= 0) ? (One << 16) : (S4 << 16);
    localparam longint unsigned P = (Num + Den / 2) / Den;
    assign sig_rom[gi] = (P > 64'd65535) ? 16'hFFFF : 16'(P);
  end

  always_comb begin
    if (feature_count_i == 7'd0) begin
      n_eff = lrs_pkg::CntW'(1);
    end else if (lrs_pkg::CntW'(feature_count_i) > MaxCnt) begin
      n_eff = MaxCnt;
    end else begin
      n_eff = lrs_pkg::CntW'(feature_count_i);
    end
    fidx_inc = (fidx_q < MaxCnt + 1'b1) ? fidx_q + 1'b1 : fidx_q;
    got      = (fidx_inc > n_eff) ? n_eff : fidx_inc;
    in_range = (fidx_q < n_eff);
  end

  assign in_ready_o = !hold_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign wt_addr_o  = fidx_q[AW-1:0];

  always_comb begin
    fidx_d = fidx_q;
    if (accept) begin
      fidx_d = in_last_i ? '0 : fidx_inc;
    end
    hold_d = hold_q;
    if (accept && in_last_i) begin
      hold_d = 1'b1;
    end else if ((push_o && !push_entry_o.meta.train) || upd_done_i) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fidx_q <= '0;
      hold_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      fidx_q <= fidx_d;
      hold_q <= hold_d;
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && s2_last_q;
    end
  end

  // Stage 1: capture item while the weight read is in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q            <= in_value_i;
      s1_in_q           <= in_range;
      s1_first_q        <= (fidx_q == '0);
      s1_last_q         <= in_last_i;
      s1_meta_q.train   <= in_cmd_i;
      s1_meta_q.label   <= in_label_i;
      s1_meta_q.len_err <= (fidx_inc != n_eff);
      s1_meta_q.got     <= got;
      s1_meta_q.n       <= n_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      sbuf[fidx_q[AW-1:0]] <= in_value_i;
    end
    sb_rdata_o <= sbuf[sb_raddr_i];
  end

  // Stage 2: product
  always_ff @(posedge clk_i) begin
    s2_prod_q  <= s1_in_q ? 48'(wt_word_i * s1_x_q) : '0;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_meta_q  <= s1_meta_q;
  end

  // Stage 3: saturating accumulate, bias loaded on the first item
  always_comb begin
    acc_base = s2_first_q ? 48'($signed({bias_i, 12'd0})) : acc_q;
    acc_sum  = 49'(acc_base) + 49'(s2_prod_q);
    if (acc_sum[48] != acc_sum[47]) begin
      acc_d = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      acc_d = acc_sum[47:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      acc_q <= acc_d;
    end
    s3_meta_q <= s2_meta_q;
  end

  // Stage 4: sigmoid lookup and hand-off
  always_comb begin
    z_off   = 49'(acc_q) + 49'(64'd1 << 31);
    sig_idx = z_off[31:32-SigIdxWLocal];
    if (acc_q < -48'sd2147483648) begin
      prob = 16'd0;
    end else if (acc_q >= 48'sd2147483648) begin
      prob = 16'hFFFF;
    end else begin
      prob = sig_rom[sig_idx];
    end
  end

  assign push_o            = s3_v_q;
  assign push_entry_o.cls  = !acc_q[47];
  assign push_entry_o.prob = prob;
  assign push_entry_o.meta = s3_meta_q;

endmodule
`default_nettype wire

### src/lrs_back.sv
`default_nettype none
module lrs_back #(
  parameter int MAX_FEATURES = 64,
  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [15:0]        learning_rate_i,
  input  wire logic [15:0]        reg_lambda_i,
  input  wire logic               q_avail_i,
  input  wire lrs_pkg::q_entry_t  q_head_i,
  output logic                    q_pop_o,
  input  wire logic [AW-1:0]      front_addr_i,
  output logic signed [31:0]      wt_word_o,
  output logic signed [31:0]      bias_o,
  output logic [AW-1:0]           sb_raddr_o,
  input  wire logic signed [15:0] sb_rdata_i,
  output logic                    upd_done_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    out_cls_o,
  output logic [15:0]             out_prob_o,
  output logic                    out_len_err_o
);

  logic [31:0] wmem [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] wvalid_q;
  logic [31:0] rd_data_q;
  logic        rd_ok_q;
  logic [AW-1:0] raddr;

  lrs_pkg::back_state_e state_q, state_d;

  logic out_valid_q, out_valid_d;
  logic signed [31:0] bias_q;

  logic [lrs_pkg::CntW-1:0] j_q, got_q, n_q;
  logic signed [17:0] err_q;
  logic signed [31:0] w_q;
  logic signed [33:0] p1_q;
  logic signed [48:0] p2_q;
  logic [49:0] mag_q;
  logic        neg_q;
  logic [40:0] lo_q, hi_q;

  logic signed [15:0] xv;
  logic signed [16:0] lam_s;
  logic signed [50:0] g;
  logic [66:0] m_sum;
  logic [34:0] qmag;
  logic signed [36:0] w_sum;
  logic signed [31:0] w_new;
  logic [16:0] emag;
  logic [32:0] bm;
  logic [17:0] bq;
  logic signed [33:0] b_sum;
  logic signed [31:0] b_new;
  logic wr_en;
  logic last_j;

  assign last_j = (j_q + 1'b1 == n_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrs_pkg::B_IDLE: if (q_pop_o && q_head_i.meta.train) state_d = lrs_pkg::B_RD;
      lrs_pkg::B_RD:   state_d = lrs_pkg::B_MUL;
      lrs_pkg::B_MUL:  state_d = lrs_pkg::B_GRAD;
      lrs_pkg::B_GRAD: state_d = lrs_pkg::B_LO;
      lrs_pkg::B_LO:   state_d = lrs_pkg::B_HI;
      lrs_pkg::B_HI:   state_d = lrs_pkg::B_WR;
      lrs_pkg::B_WR:   state_d = last_j ? lrs_pkg::B_BIAS : lrs_pkg::B_RD;
      lrs_pkg::B_BIAS: state_d = lrs_pkg::B_IDLE;
      default:         state_d = lrs_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o    = (state_q == lrs_pkg::B_IDLE) && q_avail_i && (!out_valid_q || out_ready_i);
    raddr      = (state_q == lrs_pkg::B_IDLE) ? front_addr_i : j_q[AW-1:0];
    wr_en      = (state_q == lrs_pkg::B_WR);
    upd_done_o = (state_q == lrs_pkg::B_BIAS);
  end

  assign sb_raddr_o = j_q[AW-1:0];
  assign wt_word_o  = rd_ok_q ? rd_data_q : '0;
  assign bias_o     = bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lrs_pkg::B_IDLE;
      wvalid_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        wvalid_q[j_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[j_q[AW-1:0]] <= w_new;
    end
    rd_data_q <= wmem[raddr];
    rd_ok_q   <= wvalid_q[raddr];
  end

  // Result register parts the queue from the receiver
  always_comb begin
    out_valid_d = q_pop_o ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bias_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (upd_done_o) begin
        bias_q <= b_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_cls_o     <= q_head_i.cls;
      out_prob_o    <= q_head_i.prob;
      out_len_err_o <= q_head_i.meta.len_err;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    xv    = (j_q < got_q) ? sb_rdata_i : '0;
    lam_s = $signed({1'b0, reg_lambda_i});
    g     = (51'(p1_q) <<< 4) - 51'(p2_q);
    m_sum = {hi_q, 25'd0} + 67'(lo_q) + (67'd1 << 31);
    qmag  = m_sum[66:32];
    w_sum = neg_q ? 37'(w_q) - $signed({2'b0, qmag}) : 37'(w_q) + $signed({2'b0, qmag});
    if (w_sum > 37'sd2147483647) begin
      w_new = 32'sh7FFFFFFF;
    end else if (w_sum < -37'sd2147483648) begin
      w_new = 32'sh80000000;
    end else begin
      w_new = w_sum[31:0];
    end
    emag  = err_q[17] ? 17'(-err_q) : err_q[16:0];
    bm    = 33'(emag) * 33'(learning_rate_i);
    bq    = 18'((bm + 33'd32768) >> 16);
    b_sum = err_q[17] ? 34'(bias_q) - $signed({16'd0, bq})
                      : 34'(bias_q) + $signed({16'd0, bq});
    if (b_sum > 34'sd2147483647) begin
      b_new = 32'sh7FFFFFFF;
    end else if (b_sum < -34'sd2147483648) begin
      b_new = 32'sh80000000;
    end else begin
      b_new = b_sum[31:0];
    end
  end

  // Update datapath: one weight per pass through the sequencer
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      j_q   <= '0;
      got_q <= q_head_i.meta.got;
      n_q   <= q_head_i.meta.n;
      err_q <= $signed({1'b0, q_head_i.meta.label, 16'd0}) - $signed({2'b0, q_head_i.prob});
    end
    if (state_q == lrs_pkg::B_MUL) begin
      w_q  <= wt_word_o;
      p1_q <= err_q * xv;
      p2_q <= lam_s * wt_word_o;
    end
    if (state_q == lrs_pkg::B_GRAD) begin
      neg_q <= g[50];
      mag_q <= g[50] ? 50'(-g) : g[49:0];
    end
    if (state_q == lrs_pkg::B_LO) begin
      lo_q <= 41'(mag_q[24:0]) * 41'(learning_rate_i);
    end
    if (state_q == lrs_pkg::B_HI) begin
      hi_q <= 41'(mag_q[49:25]) * 41'(learning_rate_i);
    end
    if (wr_en) begin
      j_q <= j_q + 1'b1;
    end
  end

endmodule
`default_nettype wire
